// ===== src/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtd_pkg
// Constants, command codes, state encoding and the tempering function of the
// Mersenne Twister draw block.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;

    localparam logic [9:0]  LAST_WORD    = 10'(STATE_WORDS - 1);
    localparam logic [9:0]  FAR_WRAP     = 10'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [9:0]  OFFSET_W     = 10'(TWIST_OFFSET);
    localparam logic [9:0]  WORDS_W      = 10'(STATE_WORDS);
    localparam logic [9:0]  NEVER_SEEDED = 10'(STATE_WORDS + 1);

    localparam logic [31:0] MAT_A        = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;
    localparam logic [31:0] HIGH_BIT     = 32'h80000000;
    localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;
    localparam logic [31:0] DEFAULT_MULT = 32'd6069;

    typedef enum logic [1:0] {
        CMD_DRAW    = 2'd0,
        CMD_RESEED  = 2'd1,
        CMD_BOUNDED = 2'd2
    } cmd_t;

    typedef enum logic [0:0] {
        REG_SEED_VALUE = 1'b0,
        REG_SEED_MULT  = 1'b1
    } reg_idx_t;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHK    = 11'b000_0000_0010,
        S_FILL   = 11'b000_0000_0100,
        S_TW_CUR = 11'b000_0000_1000,
        S_TW_NXT = 11'b000_0001_0000,
        S_TW_FAR = 11'b000_0010_0000,
        S_TW_WR  = 11'b000_0100_0000,
        S_RD     = 11'b000_1000_0000,
        S_TEMP   = 11'b001_0000_0000,
        S_DIV    = 11'b010_0000_0000,
        S_PUSH   = 11'b100_0000_0000
    } state_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== src/mersenne_twister_draw.sv =====
// A plain draw runs the CHK, RD, TEMP and PUSH states before the result beat.
// A bounded draw adds a bit-serial remainder; equal bounds go straight to PUSH.
// When the read position reaches 624 the draw first twists the store, one word at
// a time, through TW_NXT, TW_FAR and TW_WR and the single store read port.
// Seeding fills all 624 store words through one 32-bit multiplier, one at a time.
// Reset sets control and config registers; the store is undefined until seeded.
// ----------------------------------------------------------------------------
// mersenne_twister_draw
// MT19937 random word generator with reseed, twist, tempering and bounded draw.
// ----------------------------------------------------------------------------
module mersenne_twister_draw
    import mtd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] range_low,
    input  logic [31:0] range_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] draw_value
);

    logic [31:0] mem [0:STATE_WORDS-1];
    logic [31:0] rdata_reg;

    state_t      state_reg, state_next;
    logic [31:0] seed_reg, mult_reg;
    logic [9:0]  pos_reg, pos_next;
    logic [9:0]  k_reg, k_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] cur_reg, cur_next, nxt_reg, nxt_next;
    logic [31:0] span_reg, span_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    logic        rd_en, wr_en;
    logic [9:0]  rd_addr, wr_addr;
    logic [31:0] wr_data;
    logic [31:0] y_word, twist_word, tempered, span_calc, rem_sub;
    logic [32:0] rem_shift;
    logic [9:0]  nxt_addr, far_addr;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign draw_value = out_data_reg;

    assign nxt_addr   = (k_reg == LAST_WORD) ? 10'd0 : k_reg + 10'd1;
    assign far_addr   = (k_reg < FAR_WRAP) ? k_reg + OFFSET_W : k_reg - FAR_WRAP;
    assign y_word     = (cur_reg & HIGH_BIT) | (nxt_reg & LOW_BITS);
    assign twist_word = rdata_reg ^ (y_word >> 1) ^ (y_word[0] ? MAT_A : 32'd0);
    assign tempered   = temper(rdata_reg);
    assign span_calc  = hi_reg - lo_reg + 32'd1;
    assign rem_shift  = {rem_reg, dvd_reg[31]};
    assign rem_sub    = 32'(rem_shift - {1'b0, span_reg});

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        cmd_next       = cmd_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = k_reg;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = twist_word;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    lo_next  = range_low;
                    hi_next  = range_high;
                    case (command)
                        CMD_DRAW:
                        begin
                            state_next = S_CHK;
                        end
                        CMD_RESEED:
                        begin
                            prev_next  = seed_reg;
                            k_next     = 10'd0;
                            state_next = S_FILL;
                        end
                        CMD_BOUNDED:
                        begin
                            if (range_low == range_high)
                            begin
                                res_next   = range_low;
                                state_next = S_PUSH;
                            end
                            else
                            begin
                                state_next = S_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHK:
            begin
                k_next = 10'd0;
                if (pos_reg > WORDS_W)
                begin
                    prev_next  = DEFAULT_SEED;
                    state_next = S_FILL;
                end
                else if (pos_reg == WORDS_W)
                begin
                    state_next = S_TW_CUR;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_FILL:
            begin
                wr_en     = 1'b1;
                wr_data   = (k_reg == 10'd0) ? prev_reg : 32'(prev_reg * mult_reg);
                prev_next = wr_data;
                k_next    = k_reg + 10'd1;
                if (k_reg == LAST_WORD)
                begin
                    pos_next   = WORDS_W;
                    k_next     = 10'd0;
                    state_next = (cmd_reg == CMD_RESEED) ? S_IDLE : S_TW_CUR;
                end
            end
            S_TW_CUR:
            begin
                rd_en      = 1'b1;
                rd_addr    = 10'd0;
                state_next = S_TW_NXT;
            end
            S_TW_NXT:
            begin
                if (k_reg == 10'd0)
                begin
                    cur_next = rdata_reg;
                end
                rd_en      = 1'b1;
                rd_addr    = nxt_addr;
                state_next = S_TW_FAR;
            end
            S_TW_FAR:
            begin
                nxt_next   = rdata_reg;
                rd_en      = 1'b1;
                rd_addr    = far_addr;
                state_next = S_TW_WR;
            end
            S_TW_WR:
            begin
                wr_en    = 1'b1;
                cur_next = nxt_reg;
                k_next   = k_reg + 10'd1;
                if (k_reg == LAST_WORD)
                begin
                    pos_next   = 10'd0;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_TW_NXT;
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                pos_next   = pos_reg + 10'd1;
                state_next = S_TEMP;
            end
            S_TEMP:
            begin
                if ((cmd_reg == CMD_DRAW) || (span_calc == 32'd0))
                begin
                    res_next   = tempered;
                    state_next = S_PUSH;
                end
                else
                begin
                    span_next  = span_calc;
                    dvd_next   = tempered;
                    rem_next   = 32'd0;
                    cnt_next   = 5'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = (rem_shift >= {1'b0, span_reg}) ? rem_sub : rem_shift[31:0];
                dvd_next = {dvd_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    res_next   = lo_reg + rem_next;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= DEFAULT_SEED;
            mult_reg      <= DEFAULT_MULT;
            pos_reg       <= NEVER_SEEDED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SEED_VALUE: seed_reg <= cfg_data;
                    REG_SEED_MULT:  mult_reg <= cfg_data;
                    default:        seed_reg <= seed_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        cmd_reg      <= cmd_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        span_reg     <= span_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= NEVER_SEEDED)
        else $error("read position out of range");

    a_rd_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (pos_reg < WORDS_W))
        else $error("store read past the last word");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < span_reg))
        else $error("partial remainder not below span");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("store written while idle");

endmodule
